FILE: src/huart_pkg.sv
// ----------------------------------------------------------------------------
// huart_pkg: shared types and constants of the single-wire UART
// Word layouts, configuration bundle, frame constants and small helpers
// that the queue, the frame engine and the top level all use.
// ----------------------------------------------------------------------------
package huart_pkg;

   // Frame constants: data bits 1..8 follow the start tick, tick 9 is the stop bit.
   localparam logic [3:0]  LAST_TX_BIT   = 4'd9;
   localparam int          QUEUE_DEPTH   = 2;

   // Configuration register indexes and reset values.
   localparam logic        REG_BIT_PERIOD     = 1'b0;
   localparam logic        REG_RX_FIRST_DELAY = 1'b1;
   localparam logic [15:0] BIT_PERIOD_RESET   = 16'd16;
   localparam logic [15:0] RX_DELAY_RESET     = 16'd1;

   typedef struct packed {
      logic       line_level;
      logic       tx_write;
      logic [7:0] tx_byte;
   } huart_req_type;

   typedef struct packed {
      logic       drive_low;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       hold_full;
      logic       busy_res;
      logic       writing;
      logic       avail;
   } huart_rsp_type;

   typedef struct packed {
      logic [15:0] bit_period;
      logic [15:0] rx_first_delay;
   } huart_cfg_type;

   // A programmed value of zero is treated as one.
   function automatic logic [15:0] at_least_one(input logic [15:0] value);
      at_least_one = (value == 16'd0) ? 16'd1 : value;
   endfunction

endpackage

FILE: src/half_duplex_open_drain_uart.sv
// ----------------------------------------------------------------------------
// half_duplex_open_drain_uart: single-wire open-drain UART, 8N1
// Top level with the request queue, the frame engine and the register port.
// ----------------------------------------------------------------------------
// Each request word is one clock of the serial line: the sampled wire level
// plus an optional byte to send. Each one yields exactly one response word
// with the wire driver, a received-byte strobe and the status flags. Words
// pass a small queue and then the frame engine, which takes one word per
// clock and registers its response, so the block sustains one word per cycle
// when nothing stalls, registering each word in queue and engine; a stall on
// the response side backs up into the queue, and the request side sees
// ready drop only once the queue is full. The transmitter sends a start bit,
// eight data bits LSB first and a stop bit, each bit_period words long,
// holding one further byte in a holding register and chaining it straight on.
// A falling edge while idle starts reception: the first sample comes
// rx_first_delay words later and further samples follow one bit period
// apart; the byte is reported one bit period after the last sample. Register
// bit_period sits at byte address 0 and rx_first_delay at address 4, a value
// of zero in either behaves like one, and both should only be written while
// no words are in flight; a new value takes effect at the next bit tick.
// ----------------------------------------------------------------------------
module half_duplex_open_drain_uart
   import huart_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_line_level,
   input  logic        req_tx_write,
   input  logic [7:0]  req_tx_byte,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_drive_low,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_hold_full,
   output logic        rsp_busy_res,
   output logic        rsp_writing,
   output logic        rsp_avail,
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   huart_req_type req_word;
   huart_req_type queue_word;
   huart_rsp_type rsp_word;
   huart_cfg_type cfg_ff, cfg_in;
   logic          queue_valid;
   logic          queue_ready;
   logic          csr_write;

   assign req_word.line_level = req_line_level;
   assign req_word.tx_write   = req_tx_write;
   assign req_word.tx_byte    = req_tx_byte;

   // Register port: zero wait states, word decode on address bit 2.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_BIT_PERIOD:     cfg_in.bit_period     = csr_pwdata[15:0];
            REG_RX_FIRST_DELAY: cfg_in.rx_first_delay = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_BIT_PERIOD:     csr_prdata = {16'd0, cfg_ff.bit_period};
         REG_RX_FIRST_DELAY: csr_prdata = {16'd0, cfg_ff.rx_first_delay};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period     <= BIT_PERIOD_RESET;
         cfg_ff.rx_first_delay <= RX_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   huart_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_word  (req_word),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_word   (queue_word)
   );

   huart_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .word_valid (queue_valid),
      .word_ready (queue_ready),
      .word       (queue_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   assign rsp_drive_low = rsp_word.drive_low;
   assign rsp_rx_valid  = rsp_word.rx_valid;
   assign rsp_rx_byte   = rsp_word.rx_byte;
   assign rsp_hold_full = rsp_word.hold_full;
   assign rsp_busy_res  = rsp_word.busy_res;
   assign rsp_writing   = rsp_word.writing;
   assign rsp_avail     = rsp_word.avail;

endmodule

FILE: src/huart_queue.sv
// ----------------------------------------------------------------------------
// huart_queue: input word queue
// Accepts line-sample words from the request channel and holds them until
// the frame engine is free to take them.
// ----------------------------------------------------------------------------
module huart_queue
   import huart_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  huart_req_type push_word,
   output logic          pop_valid,
   input  logic          pop_ready,
   output huart_req_type pop_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   huart_req_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");
   a_push_moves: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not rise on push");
`endif

endmodule

FILE: src/huart_engine.sv
// ----------------------------------------------------------------------------
// huart_engine: frame engine and result register
// Advances the bit timer, transmitter, receiver and holding register by one
// clock of the serial line per word, and registers the resulting status word.
// ----------------------------------------------------------------------------
module huart_engine
   import huart_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  huart_cfg_type cfg,
   input  logic          word_valid,
   output logic          word_ready,
   input  huart_req_type word,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output huart_rsp_type rsp_word
);

   logic [15:0] tick_timer_ff, tick_timer_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic        next_level_ff, next_level_in;
   logic        line_low_ff, line_low_in;
   logic [7:0]  hold_byte_ff, hold_byte_in;
   logic        hold_valid_ff, hold_valid_in;
   logic        busy_flag_ff, busy_flag_in;
   logic        write_flag_ff, write_flag_in;
   logic        avail_flag_ff, avail_flag_in;
   logic        prev_level_ff, prev_level_in;
   logic        rx_valid_in;
   logic [7:0]  rx_byte_in;
   logic        rsp_valid_ff, rsp_valid_in;
   huart_rsp_type rsp_word_ff, rsp_word_in;
   logic        step;
   logic [3:0]  bit_inc;

   assign word_ready = !rsp_valid_ff || rsp_ready;
   assign step       = word_valid && word_ready;
   assign bit_inc    = bit_index_ff + 4'd1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   always_comb begin
      tick_timer_in = tick_timer_ff;
      bit_index_in  = bit_index_ff;
      shift_byte_in = shift_byte_ff;
      next_level_in = next_level_ff;
      line_low_in   = line_low_ff;
      hold_byte_in  = hold_byte_ff;
      hold_valid_in = hold_valid_ff;
      busy_flag_in  = busy_flag_ff;
      write_flag_in = write_flag_ff;
      avail_flag_in = avail_flag_ff;
      prev_level_in = prev_level_ff;
      rx_valid_in   = 1'b0;
      rx_byte_in    = 8'd0;
      if (step) begin
         // Bit timer of the frame in progress.
         if (busy_flag_ff) begin
            if (tick_timer_ff <= 16'd1) begin
               tick_timer_in = at_least_one(cfg.bit_period);
               bit_index_in  = bit_inc;
               if (write_flag_ff) begin
                  line_low_in = !next_level_ff;
                  if (bit_inc > LAST_TX_BIT) begin
                     bit_index_in  = 4'd0;
                     next_level_in = 1'b0;
                     busy_flag_in  = 1'b0;
                     write_flag_in = 1'b0;
                     avail_flag_in = 1'b0;
                  end else if (bit_inc == LAST_TX_BIT) begin
                     next_level_in = 1'b1;
                  end else begin
                     next_level_in = shift_byte_ff[0];
                     shift_byte_in = {1'b0, shift_byte_ff[7:1]};
                  end
               end else begin
                  if (bit_inc <= LAST_TX_BIT) begin
                     shift_byte_in = {word.line_level, shift_byte_ff[7:1]};
                  end else begin
                     rx_valid_in   = 1'b1;
                     rx_byte_in    = shift_byte_ff;
                     avail_flag_in = 1'b1;
                     busy_flag_in  = 1'b0;
                     bit_index_in  = 4'd0;
                     next_level_in = 1'b0;
                  end
               end
            end else begin
               tick_timer_in = tick_timer_ff - 16'd1;
            end
         end
         // A held byte goes out as soon as the line is free.
         if (!busy_flag_in && hold_valid_ff) begin
            hold_valid_in = 1'b0;
            shift_byte_in = hold_byte_ff;
            busy_flag_in  = 1'b1;
            write_flag_in = 1'b1;
            bit_index_in  = 4'd0;
            next_level_in = 1'b0;
            line_low_in   = 1'b0;
            tick_timer_in = at_least_one(cfg.bit_period);
         end
         // New byte: start at once when free, else park it if there is room.
         if (word.tx_write && !hold_valid_in) begin
            if (!busy_flag_in) begin
               shift_byte_in = word.tx_byte;
               busy_flag_in  = 1'b1;
               write_flag_in = 1'b1;
               bit_index_in  = 4'd0;
               next_level_in = 1'b0;
               line_low_in   = 1'b0;
               tick_timer_in = at_least_one(cfg.bit_period);
            end else begin
               hold_byte_in  = word.tx_byte;
               hold_valid_in = 1'b1;
            end
         end
         // Falling edge while idle for the whole cycle starts reception.
         if (!busy_flag_ff && !busy_flag_in && prev_level_ff && !word.line_level) begin
            busy_flag_in  = 1'b1;
            write_flag_in = 1'b0;
            bit_index_in  = 4'd0;
            tick_timer_in = at_least_one(cfg.rx_first_delay);
         end
         prev_level_in = word.line_level;
      end
   end

   always_comb begin
      rsp_word_in.drive_low = line_low_in;
      rsp_word_in.rx_valid  = rx_valid_in;
      rsp_word_in.rx_byte   = rx_byte_in;
      rsp_word_in.hold_full = hold_valid_in;
      rsp_word_in.busy_res  = busy_flag_in;
      rsp_word_in.writing   = write_flag_in;
      rsp_word_in.avail     = avail_flag_in;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_timer_ff <= '0;
         bit_index_ff  <= '0;
         shift_byte_ff <= '0;
         next_level_ff <= 1'b0;
         line_low_ff   <= 1'b0;
         hold_byte_ff  <= '0;
         hold_valid_ff <= 1'b0;
         busy_flag_ff  <= 1'b0;
         write_flag_ff <= 1'b0;
         avail_flag_ff <= 1'b0;
         prev_level_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_timer_ff <= tick_timer_in;
         bit_index_ff  <= bit_index_in;
         shift_byte_ff <= shift_byte_in;
         next_level_ff <= next_level_in;
         line_low_ff   <= line_low_in;
         hold_byte_ff  <= hold_byte_in;
         hold_valid_ff <= hold_valid_in;
         busy_flag_ff  <= busy_flag_in;
         write_flag_ff <= write_flag_in;
         avail_flag_ff <= avail_flag_in;
         prev_level_ff <= prev_level_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

`ifndef SYNTHESIS
   a_write_is_busy: assert property (@(posedge clock) disable iff (reset)
      write_flag_ff |-> busy_flag_ff)
      else $error("transmit direction set outside a frame");
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !busy_flag_ff |-> bit_index_ff == 4'd0 && !line_low_ff)
      else $error("bit index or driver left set while idle");
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= LAST_TX_BIT)
      else $error("bit index ran past the stop bit");
   a_rx_sets_avail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.rx_valid |-> rsp_word_ff.avail)
      else $error("received word without avail");
`endif

endmodule
